### hw/rtl/dalt_pkg.sv
// Package for the device address learning table.
// Holds the item types and status codes shared by the search engine and the top level.
// No dependencies.
package dalt_pkg;

  // Widths of the fields of one item.
  localparam int unsigned MacW   = 48;
  localparam int unsigned IpW    = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned IndexW = 10;
  localparam int unsigned CountW = 11;

  typedef logic [StatW-1:0]  status_t;
  typedef logic [IndexW-1:0] index_t;
  typedef logic [CountW-1:0] count_t;

  // Status codes of a result item.
  localparam status_t StUpdated = 2'd0;
  localparam status_t StAdded   = 2'd1;
  localparam status_t StFull    = 2'd2;

  // One observation.
  typedef struct packed {
    logic [MacW-1:0]  mac_address;
    logic [IpW-1:0]   ip_address;
    logic [TimeW-1:0] timestamp;
  } in_item_t;

  // One result.
  typedef struct packed {
    status_t status;
    index_t  entry_index;
    count_t  entry_count;
  } out_item_t;

endpackage

### hw/rtl/dalt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module dalt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dalt_search.sv
// Search engine of the device address learning table: the table memories, the fill count
// and the state machine that scans, updates or appends. Depends on dalt_pkg and dalt_ram.
module dalt_search #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dalt_pkg::in_item_t  in_item_i,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output dalt_pkg::out_item_t res_o
);

  localparam int unsigned IdxW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned InfoW = dalt_pkg::IpW + dalt_pkg::TimeW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESULT
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     issue_q, issue_d;
  logic                cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  dalt_pkg::out_item_t res_q, res_d;
  dalt_pkg::in_item_t  item_q;

  logic                accept;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic [dalt_pkg::MacW-1:0] rd_mac;
  logic                hit;
  logic                exhausted;
  logic                full;
  logic                wr_mac;
  logic                wr_info;
  logic                wr_first;
  logic [IdxW-1:0]     wr_addr;
  logic [InfoW-1:0]    wr_info_data;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // Scan bookkeeping: one read is issued per cycle and compared in the cycle after.
  assign rd_en     = (state_q == S_SEARCH) && (issue_q < cnt_q);
  assign rd_addr   = issue_q[IdxW-1:0];
  assign hit       = (state_q == S_SEARCH) && cmp_valid_q && (rd_mac == item_q.mac_address);
  assign exhausted = (state_q == S_SEARCH) && !cmp_valid_q && !rd_en;
  assign full      = (cnt_q == CntW'(MAX_ENTRIES));

  // Write-back: a hit refreshes the address and last-seen time, a miss appends unless the table is full.
  assign wr_info      = hit || (exhausted && !full);
  assign wr_mac       = exhausted && !full;
  assign wr_first     = exhausted && !full;
  assign wr_addr      = hit ? cmp_idx_q : cnt_q[IdxW-1:0];
  assign wr_info_data = {item_q.ip_address, item_q.timestamp};

  dalt_ram #(
    .Width(dalt_pkg::MacW),
    .Depth(MAX_ENTRIES)
  ) u_mac_ram (
    .clk_i  (clk_i),
    .we_i   (wr_mac),
    .waddr_i(wr_addr),
    .wdata_i(item_q.mac_address),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_mac)
  );

  // IPv4 address and last-seen time share one memory row.
  dalt_ram #(
    .Width(InfoW),
    .Depth(MAX_ENTRIES)
  ) u_info_ram (
    .clk_i  (clk_i),
    .we_i   (wr_info),
    .waddr_i(wr_addr),
    .wdata_i(wr_info_data),
    .re_i   (1'b0),
    .raddr_i(rd_addr),
    .rdata_o()
  );

  dalt_ram #(
    .Width(dalt_pkg::TimeW),
    .Depth(MAX_ENTRIES)
  ) u_first_ram (
    .clk_i  (clk_i),
    .we_i   (wr_first),
    .waddr_i(wr_addr),
    .wdata_i(item_q.timestamp),
    .re_i   (1'b0),
    .raddr_i(rd_addr),
    .rdata_o()
  );

  // Next-state logic.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    issue_d     = issue_q;
    cmp_valid_d = cmp_valid_q;
    cmp_idx_d   = cmp_idx_q;
    res_d       = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d     = S_SEARCH;
          issue_d     = '0;
          cmp_valid_d = 1'b0;
        end
      end
      S_SEARCH: begin
        cmp_valid_d = rd_en;
        cmp_idx_d   = rd_addr;
        if (rd_en) begin
          issue_d = issue_q + CntW'(1);
        end
        if (hit) begin
          state_d           = S_RESULT;
          res_d.status      = dalt_pkg::StUpdated;
          res_d.entry_index = dalt_pkg::index_t'(cmp_idx_q);
          res_d.entry_count = dalt_pkg::count_t'(cnt_q);
        end else if (exhausted) begin
          state_d = S_RESULT;
          if (full) begin
            res_d.status      = dalt_pkg::StFull;
            res_d.entry_index = '0;
            res_d.entry_count = dalt_pkg::count_t'(cnt_q);
          end else begin
            cnt_d             = cnt_q + CntW'(1);
            res_d.status      = dalt_pkg::StAdded;
            res_d.entry_index = dalt_pkg::index_t'(cnt_q[IdxW-1:0]);
            res_d.entry_count = dalt_pkg::count_t'(cnt_q + CntW'(1));
          end
        end
      end
      S_RESULT: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, fill count and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      issue_q     <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      issue_q     <= issue_d;
      cmp_valid_q <= cmp_valid_d;
      cmp_idx_q   <= cmp_idx_d;
      res_q       <= res_d;
    end
  end

  // Observation held for the whole search.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

endmodule

### hw/rtl/device_address_learning_table_unit.sv
// Top level of the device address learning table: search engine plus output register.
// Depends on dalt_pkg and dalt_search.
//
// Each item is one observation of a hardware address with its IPv4 address and a
// timestamp. The table is searched from entry 0 upward for the hardware address; a hit
// refreshes that entry's IPv4 address and last-seen time, a miss appends a new entry, and
// a miss on a full table drops the observation with the table-full status. One item is
// worked on at a time. The scan reads the hardware-address memory through its single
// read port, one entry per cycle; a hit stops it at that entry and a miss reads every
// filled entry. A finished result waits in an output register, so the next item may be
// accepted while it is still stalled. There is no clearing pass after reset; of the
// table, only the fill count is cleared.
module device_address_learning_table_unit #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dalt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dalt_pkg::out_item_t out_item_o
);

  logic                res_valid;
  logic                res_take;
  dalt_pkg::out_item_t res;
  logic                out_valid_q, out_valid_d;
  dalt_pkg::out_item_t out_item_q;

  dalt_search #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_o      (res)
  );

  // The output register takes a result when it is empty or being emptied.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### verif/tb_top.sv
// Self-checking testbench for device_address_learning_table_unit.
// Depends on dalt_pkg and the RTL of the table; a scoreboard class predicts every
// lookup outcome while plain tasks drive observations and a process drives random stalls.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned RandItems  = 567;
  localparam int unsigned DrainPoint = 300;

  // Keeps a private copy of the table and the outcomes still owed by the block.
  class lookup_scoreboard;
    bit [dalt_pkg::MacW-1:0]  mac_tbl[];
    bit [dalt_pkg::IpW-1:0]   ip_tbl[];
    bit [dalt_pkg::TimeW-1:0] first_seen_tbl[];
    bit [dalt_pkg::TimeW-1:0] last_seen_tbl[];
    int unsigned              depth;
    int unsigned              fill;
    int unsigned              mismatches;
    int unsigned              results_seen;
    dalt_pkg::out_item_t      lookup_outcomes[$];

    function new(int unsigned entries);
      depth          = entries;
      mac_tbl        = new[entries];
      ip_tbl         = new[entries];
      first_seen_tbl = new[entries];
      last_seen_tbl  = new[entries];
      fill           = 0;
      mismatches     = 0;
      results_seen   = 0;
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] %s", $realtime, msg);
      mismatches++;
    endtask

    // Searches the filled entries in order, then updates, appends or drops.
    function void note_observation(dalt_pkg::in_item_t obs);
      dalt_pkg::out_item_t outcome;
      bit                  found;
      int unsigned         slot;
      found = 1'b0;
      slot  = 0;
      for (int unsigned k = 0; k < fill; k++) begin
        if (!found && mac_tbl[k] == obs.mac_address) begin
          found = 1'b1;
          slot  = k;
        end
      end
      if (found) begin
        ip_tbl[slot]        = obs.ip_address;
        last_seen_tbl[slot] = obs.timestamp;
        outcome.status      = dalt_pkg::StUpdated;
      end else if (fill < depth) begin
        slot                 = fill;
        mac_tbl[slot]        = obs.mac_address;
        ip_tbl[slot]         = obs.ip_address;
        first_seen_tbl[slot] = obs.timestamp;
        last_seen_tbl[slot]  = obs.timestamp;
        fill++;
        outcome.status       = dalt_pkg::StAdded;
      end else begin
        slot           = 0;
        outcome.status = dalt_pkg::StFull;
      end
      outcome.entry_index = dalt_pkg::index_t'(slot);
      outcome.entry_count = dalt_pkg::count_t'(fill);
      lookup_outcomes.push_back(outcome);
    endfunction

    // Compares one accepted result with the oldest outcome owed.
    task check_result(dalt_pkg::out_item_t got);
      dalt_pkg::out_item_t want;
      results_seen++;
      if (lookup_outcomes.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: status %0d index %0d count %0d",
                                got.status, got.entry_index, got.entry_count));
        return;
      end
      want = lookup_outcomes.pop_front();
      if (got.status !== want.status)
        flag_mismatch($sformatf("status: got %0d, expected %0d", got.status, want.status));
      if (got.entry_index !== want.entry_index)
        flag_mismatch($sformatf("entry_index: got %0d, expected %0d",
                                got.entry_index, want.entry_index));
      if (got.entry_count !== want.entry_count)
        flag_mismatch($sformatf("entry_count: got %0d, expected %0d",
                                got.entry_count, want.entry_count));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  dalt_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  dalt_pkg::out_item_t out_item_o;
  bit                  sender_calm;

  lookup_scoreboard sb = new(TableDepth);

  always #5 clk_i = ~clk_i;

  device_address_learning_table_unit #(
    .MAX_ENTRIES(TableDepth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Mostly short idle stretches, a few long ones.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit [dalt_pkg::MacW-1:0] random_mac();
    bit [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[dalt_pkg::MacW-1:0];
  endfunction

  function automatic dalt_pkg::in_item_t observation_for(bit [dalt_pkg::MacW-1:0] mac);
    dalt_pkg::in_item_t obs;
    obs.mac_address = mac;
    obs.ip_address  = $urandom;
    obs.timestamp   = $urandom;
    return obs;
  endfunction

  // Both handshakes are sampled at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_observation(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    end
  end

  // Offers one item after an optional gap and holds it until accepted.
  task automatic send_observation(input dalt_pkg::in_item_t obs);
    int unsigned gap;
    gap = 0;
    if (!sender_calm && $urandom_range(0, 1) == 1) gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= obs;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering items until every owed result has come back.
  task automatic drain_outcomes();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.lookup_outcomes.size() != 0);
  endtask

  // Receiver: random stalls, calm stretches and one long hold-off early on.
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    bit          calm;
    bit          hold_armed;
    stall_left  = 0;
    calm_left   = 0;
    calm        = 1'b0;
    hold_armed  = 1'b1;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(50, 300);
      end
      calm_left--;
      if (stall_left == 0) begin
        if (hold_armed && sb.results_seen >= 8) begin
          stall_left = LongHold;
          hold_armed = 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
          stall_left = idle_len();
        end
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Stimulus: directed corner cases, then a fixed number of random observations.
  initial begin
    dalt_pkg::in_item_t        directed[$];
    bit [dalt_pkg::MacW-1:0]   mac;
    int unsigned               rand_count;
    int unsigned               hit_pct;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    sender_calm = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes, hits on the first and latest entries, near-miss addresses.
    directed.push_back(dalt_pkg::in_item_t'{48'h0, 32'h0, 32'h0});
    directed.push_back(dalt_pkg::in_item_t'{48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF});
    directed.push_back(dalt_pkg::in_item_t'{48'h0, 32'hFFFF_FFFF, 32'h1});
    directed.push_back(dalt_pkg::in_item_t'{48'hFFFF_FFFF_FFFF, 32'h0, 32'h0});
    directed.push_back(dalt_pkg::in_item_t'{48'hAAAA_AAAA_AAAA, 32'h5555_5555,
                                            32'hAAAA_AAAA});
    directed.push_back(dalt_pkg::in_item_t'{48'h5555_5555_5555, 32'hAAAA_AAAA,
                                            32'h5555_5555});
    directed.push_back(dalt_pkg::in_item_t'{48'h0000_0000_0001, 32'h0000_0001,
                                            32'h8000_0000});
    directed.push_back(dalt_pkg::in_item_t'{48'h8000_0000_0000, 32'h8000_0000,
                                            32'h0000_0001});
    directed.push_back(dalt_pkg::in_item_t'{48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF,
                                            32'hFFFF_FFFE});
    directed.push_back(dalt_pkg::in_item_t'{48'h5555_5555_5555, 32'h0, 32'hFFFF_FFFF});
    directed.push_back(dalt_pkg::in_item_t'{48'h7FFF_FFFF_FFFF, 32'h0A00_0001,
                                            32'h0000_1000});
    directed.push_back(dalt_pkg::in_item_t'{48'h0, 32'hC0A8_0001, 32'h0000_2000});
    directed.push_back(dalt_pkg::in_item_t'{48'hFFFF_FFFE_FFFE, 32'hFFFF_FFFF, 32'h0});
    foreach (directed[k]) send_observation(directed[k]);

    // Random part: mostly new addresses, with refreshes of entries already learned.
    rand_count = 0;
    while (rand_count < RandItems) begin
      if (rand_count == DrainPoint) drain_outcomes();
      hit_pct = (sb.fill == TableDepth) ? 55 : 15;
      if (sb.fill != 0 && $urandom_range(0, 99) < hit_pct)
        mac = sb.mac_tbl[$urandom_range(0, sb.fill - 1)];
      else
        mac = random_mac();
      send_observation(observation_for(mac));
      rand_count++;
      if (rand_count % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    end

    drain_outcomes();
    repeat (TableDepth + 8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
hw/rtl/dalt_pkg.sv
hw/rtl/dalt_ram.sv
hw/rtl/dalt_search.sv
hw/rtl/device_address_learning_table_unit.sv
verif/tb_top.sv
